/* rtl/sfc_pkg.sv */
// Shared types and constants for the serial frame checker.
package sfc_pkg;

   localparam int unsigned CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_HANDSET_ID    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONTROLLER_ID = 4'd1;

   localparam logic [7:0] HANDSET_ID_RST    = 8'd241;
   localparam logic [7:0] CONTROLLER_ID_RST = 8'd242;

   localparam logic [7:0] END_MARKER     = 8'h7E;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd6;

   localparam int unsigned OUT_PARAMS = 4;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_COUNT_BIG   = 3'd1,
      ST_SRC_MISMATCH = 3'd2,
      ST_SRC_UNKNOWN = 3'd3,
      ST_SIZE_BAD    = 3'd4,
      ST_CSUM_BAD    = 3'd5,
      ST_END_BAD     = 3'd6
   } sfc_status_type;

   // one received byte moving from the input register into the frame logic
   typedef struct packed {
      logic       fire;
      logic [7:0] rx_byte;
      logic       buffer_end;
   } sfc_item_type;

   typedef struct packed {
      logic                          valid;
      sfc_status_type                status;
      logic [7:0]                    source_id;
      logic [7:0]                    command_code;
      logic [2:0]                    param_count;
      logic [OUT_PARAMS-1:0][7:0]    param_bytes;
   } sfc_result_type;

endpackage

/* rtl/sfc_in_stage.sv */
// Input register for received bytes.
module sfc_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 slot_free,
   output sfc_pkg::sfc_item_type item
);
   import sfc_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       advance;
   logic       accept;

   // only a buffer end produces a result, so only it needs a free output slot
   assign advance    = !last_ff || slot_free;
   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign item.fire       = valid_ff && advance;
   assign item.rx_byte    = byte_ff;
   assign item.buffer_end = last_ff;

endmodule

/* rtl/sfc_frame_core.sv */
// Per-buffer frame state, source id registers and the frame checks.
module sfc_frame_core #(
   parameter int unsigned MAX_PARAMS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfc_pkg::sfc_item_type         item,
   input  logic                          csr_valid,
   input  logic [sfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data,
   output sfc_pkg::sfc_result_type       result
);
   import sfc_pkg::*;

   localparam int unsigned PIDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam logic [7:0]  MAX_P8 = 8'(MAX_PARAMS);

   logic [7:0] handset_id_ff, controller_id_ff;

   logic [7:0] byte_index_ff, byte_index_in;
   logic [7:0] first_src_ff, first_src_in;
   logic [7:0] second_src_ff, second_src_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] param_ff [MAX_PARAMS];

   logic [7:0]        b;
   logic [7:0]        k;
   logic              p_we;
   logic [PIDX_W-1:0] p_idx;
   logic [8:0]        size;
   sfc_status_type    status;
   logic              ok;

   assign b     = item.rx_byte;
   assign k     = byte_index_ff - 8'd4;
   assign p_idx = k[PIDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         handset_id_ff    <= HANDSET_ID_RST;
         controller_id_ff <= CONTROLLER_ID_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_HANDSET_ID:    handset_id_ff    <= csr_data;
            REG_CONTROLLER_ID: controller_id_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // header capture and running checksum for the current byte
   always_comb begin
      first_src_in  = first_src_ff;
      second_src_in = second_src_ff;
      command_in    = command_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      p_we          = 1'b0;
      case (byte_index_ff)
         8'd0: first_src_in  = b;
         8'd1: second_src_in = b;
         8'd2: begin
            command_in = b;
            sum_in     = sum_ff + b;
         end
         8'd3: begin
            count_in = b;
            sum_in   = sum_ff + b;
         end
         default: begin
            if (count_ff <= MAX_P8 && k < count_ff && k < MAX_P8) begin
               p_we   = 1'b1;
               sum_in = sum_ff + b;
            end
         end
      endcase
   end

   // checks in priority order, on the state including this byte
   assign size = {1'b0, byte_index_ff} + 9'd1;

   always_comb begin
      if (count_in > MAX_P8) begin
         status = ST_COUNT_BIG;
      end else if (first_src_in != second_src_in) begin
         status = ST_SRC_MISMATCH;
      end else if (first_src_in != handset_id_ff && first_src_in != controller_id_ff) begin
         status = ST_SRC_UNKNOWN;
      end else if (size != FRAME_OVERHEAD + {1'b0, count_in}) begin
         status = ST_SIZE_BAD;
      end else if (prev_ff != sum_in) begin
         status = ST_CSUM_BAD;
      end else if (b != END_MARKER) begin
         status = ST_END_BAD;
      end else begin
         status = ST_OK;
      end
   end

   assign ok = (status == ST_OK);

   always_comb begin
      if (item.buffer_end) begin
         byte_index_in = '0;
         prev_in       = '0;
      end else begin
         prev_in       = b;
         byte_index_in = (byte_index_ff == 8'hFF) ? byte_index_ff : byte_index_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         first_src_ff  <= '0;
         second_src_ff <= '0;
         command_ff    <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         prev_ff       <= '0;
      end else if (item.fire) begin
         byte_index_ff <= byte_index_in;
         prev_ff       <= prev_in;
         if (item.buffer_end) begin
            first_src_ff  <= '0;
            second_src_ff <= '0;
            command_ff    <= '0;
            count_ff      <= '0;
            sum_ff        <= '0;
         end else begin
            first_src_ff  <= first_src_in;
            second_src_ff <= second_src_in;
            command_ff    <= command_in;
            count_ff      <= count_in;
            sum_ff        <= sum_in;
         end
      end
   end

   // parameter bytes are always rewritten before a good frame reads them
   always_ff @(posedge clock) begin
      if (item.fire && p_we) begin
         param_ff[p_idx] <= b;
      end
   end

   for (genvar j = 0; j < OUT_PARAMS; j++) begin : g_out
      if (j < MAX_PARAMS) begin : g_have
         logic [7:0] pv;
         assign pv = (p_we && p_idx == PIDX_W'(j)) ? b : param_ff[j];
         assign result.param_bytes[j] = (ok && 8'(j) < count_in) ? pv : 8'd0;
      end else begin : g_none
         assign result.param_bytes[j] = 8'd0;
      end
   end

   assign result.valid        = item.fire && item.buffer_end;
   assign result.status       = status;
   assign result.source_id    = ok ? first_src_in : 8'd0;
   assign result.command_code = ok ? command_in : 8'd0;
   assign result.param_count  = ok ? count_in[2:0] : 3'd0;

endmodule

/* rtl/sfc_out_stage.sv */
// Result register toward the response channel.
module sfc_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  sfc_pkg::sfc_result_type result,
   output logic                    slot_free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [55:0]             rsp_tdata,  // source_id, command_code, param_count, param_byte0..3
   output logic [2:0]              rsp_tuser   // status
);
   import sfc_pkg::*;

   logic           valid_ff, valid_in;
   sfc_result_type res_ff;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.status;
   assign rsp_tdata  = {5'd0,
                        res_ff.param_bytes[3], res_ff.param_bytes[2],
                        res_ff.param_bytes[1], res_ff.param_bytes[0],
                        res_ff.param_count, res_ff.command_code, res_ff.source_id};

endmodule

/* rtl/serial_frame_checker_top.sv */
// Serial frame checker: validates received additive-checksum frames.
//
// Takes one received byte per cycle on req_ unless stalled (tlast marks the last byte of
// a buffer) and gives one result per buffer on rsp_, once its last byte has passed the
// input register and the result register. A byte passes from the input register through
// the frame checks and state update, and a buffer end lands in the result register. The
// input stalls only when a buffer end sits in the input register while the previous
// result has not been taken. rsp_tuser carries the status; on any failure rsp_tdata is
// all zero. Source id registers are written through csr_, which is always ready.
module serial_frame_checker_top #(
   parameter int unsigned MAX_PARAMS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // rx_byte
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [55:0]                   rsp_tdata,  // source_id, command_code, param_count,
                                                     // param_byte0..param_byte3, zero pad
   output logic [2:0]                    rsp_tuser,  // status
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);
   import sfc_pkg::*;

   sfc_item_type   item;
   sfc_result_type result;
   logic           slot_free;

   assign csr_ready = 1'b1;

   sfc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .slot_free  (slot_free),
      .item       (item)
   );

   sfc_frame_core #(.MAX_PARAMS(MAX_PARAMS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (result)
   );

   sfc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/sfc_checker.sv */
// Port-level checks for the serial frame checker, bound to the top level.
module sfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import sfc_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == 56'd0)
      else $error("failed frame carries nonzero fields");

   a_no_params: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_OK && rsp_tdata[18:16] == 3'd0 |-> rsp_tdata[55:19] == '0)
      else $error("parameter bytes present with zero count");

endmodule

bind serial_frame_checker_top sfc_checker u_sfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* sim/sfc_frame_monitor.sv */
// Frame checker scoreboard: watches the serial frame checker's channels and compares verdicts.
`timescale 1ns / 100ps

module sfc_frame_monitor #(
   parameter int unsigned MAX_PARAMS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [55:0]                   rsp_tdata,
   input  logic [2:0]                    rsp_tuser,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [sfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data,
   output int                            fail_count,
   output int                            verdicts_pending
);
   import sfc_pkg::*;

   localparam int unsigned REPORT_CAP = 100;

   typedef struct packed {
      sfc_status_type   status;
      logic [7:0]       source_id;
      logic [7:0]       command_code;
      logic [2:0]       param_count;
      logic [3:0][7:0]  param_bytes;
   } frame_verdict_type;

   frame_verdict_type pending_verdicts[$];

   // source ids as last written
   logic [7:0] handset_id;
   logic [7:0] controller_id;

   // per-buffer decode state
   logic [7:0] byte_index;
   logic [7:0] first_source;
   logic [7:0] second_source;
   logic [7:0] command_store;
   logic [7:0] count_store;
   logic [7:0] param_store [MAX_PARAMS];
   logic [7:0] running_sum;
   logic [7:0] previous_byte;

   task automatic clear_buffer();
      byte_index    = '0;
      first_source  = '0;
      second_source = '0;
      command_store = '0;
      count_store   = '0;
      for (int i = 0; i < MAX_PARAMS; i++) param_store[i] = '0;
      running_sum   = '0;
      previous_byte = '0;
   endtask

   function automatic sfc_status_type judge_frame(input logic [7:0] last_byte);
      int unsigned frame_len;
      frame_len = int'(byte_index) + 1;
      if (count_store > MAX_PARAMS)
         return ST_COUNT_BIG;
      if (first_source != second_source)
         return ST_SRC_MISMATCH;
      if (first_source != handset_id && first_source != controller_id)
         return ST_SRC_UNKNOWN;
      if (frame_len != 6 + int'(count_store))
         return ST_SIZE_BAD;
      if (previous_byte != running_sum)
         return ST_CSUM_BAD;
      if (last_byte != END_MARKER)
         return ST_END_BAD;
      return ST_OK;
   endfunction

   // fold one received byte into the buffer state; a buffer end queues a verdict
   task automatic absorb_byte(input logic [7:0] rx_byte, input logic buffer_end);
      int unsigned       k;
      frame_verdict_type verdict;
      case (byte_index)
         8'd0: first_source = rx_byte;
         8'd1: second_source = rx_byte;
         8'd2: begin
            command_store = rx_byte;
            running_sum   = running_sum + rx_byte;
         end
         8'd3: begin
            count_store = rx_byte;
            running_sum = running_sum + rx_byte;
         end
         default: begin
            k = int'(byte_index) - 4;
            if (count_store <= MAX_PARAMS && k < count_store && k < MAX_PARAMS) begin
               param_store[k] = rx_byte;
               running_sum    = running_sum + rx_byte;
            end
         end
      endcase
      if (!buffer_end) begin
         previous_byte = rx_byte;
         if (byte_index != 8'd255) byte_index = byte_index + 8'd1;
         return;
      end
      verdict        = '0;
      verdict.status = judge_frame(rx_byte);
      if (verdict.status == ST_OK) begin
         verdict.source_id    = first_source;
         verdict.command_code = command_store;
         verdict.param_count  = count_store[2:0];
         for (int j = 0; j < 4; j++)
            if (j < MAX_PARAMS && j < count_store) verdict.param_bytes[j] = param_store[j];
      end
      pending_verdicts.push_back(verdict);
      clear_buffer();
   endtask

   task automatic check_field(input string field_name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         if (fail_count < REPORT_CAP)
            $display("%0t: %s expected %0h actual %0h", $time, field_name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_verdict_type want;
      if (reset) begin
         handset_id    = HANDSET_ID_RST;
         controller_id = CONTROLLER_ID_RST;
         clear_buffer();
         pending_verdicts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               if (fail_count < REPORT_CAP)
                  $display("%0t: unexpected result expected none actual status %0d data %0h",
                           $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_verdicts.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_tuser));
               check_field("source_id", want.source_id, rsp_tdata[7:0]);
               check_field("command_code", want.command_code, rsp_tdata[15:8]);
               check_field("param_count", 8'(want.param_count), 8'(rsp_tdata[18:16]));
               check_field("param_byte0", want.param_bytes[0], rsp_tdata[26:19]);
               check_field("param_byte1", want.param_bytes[1], rsp_tdata[34:27]);
               check_field("param_byte2", want.param_bytes[2], rsp_tdata[42:35]);
               check_field("param_byte3", want.param_bytes[3], rsp_tdata[50:43]);
               check_field("pad", 8'd0, 8'(rsp_tdata[55:51]));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_HANDSET_ID)
               handset_id = csr_data;
            else if (csr_index == REG_CONTROLLER_ID)
               controller_id = csr_data;
         end
         if (req_tvalid && req_tready)
            absorb_byte(req_tdata, req_tlast);
      end
      verdicts_pending = pending_verdicts.size();
   end

endmodule

/* sim/tb_serial_frame_checker_top.sv */
// Testbench top: drives byte buffers and source id writes into the serial frame checker.
`timescale 1ns / 100ps

module tb_serial_frame_checker_top;
   import sfc_pkg::*;

   localparam int unsigned MAX_PARAMS  = 4;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          SETTLE      = 8;
   localparam int          CHUNK_BYTES = 150;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [55:0]          rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_data = '0;

   int fail_count;
   int verdicts_pending;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent = 0;

   logic [7:0] handset_id = HANDSET_ID_RST;
   logic [7:0] controller_id = CONTROLLER_ID_RST;
   logic [7:0] frame_q[$];

   serial_frame_checker_top #(.MAX_PARAMS(MAX_PARAMS)) dut (.*);

   sfc_frame_monitor #(.MAX_PARAMS(MAX_PARAMS)) u_monitor (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("serial_frame_checker_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic push_byte(input logic [7:0] rx_byte, input logic buffer_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx_byte;
      req_tlast  <= buffer_end;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame_q();
      foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // builds source, source, command, count, params, checksum, end marker
   task automatic make_frame(input logic [7:0] src_a, input logic [7:0] src_b,
                             input logic [7:0] cmd, input logic [7:0] count,
                             input int n_params, input logic [31:0] prm,
                             input logic [7:0] csum_flip, input logic [7:0] end_byte);
      logic [7:0] sum;
      logic [7:0] p;
      frame_q.delete();
      frame_q.push_back(src_a);
      frame_q.push_back(src_b);
      frame_q.push_back(cmd);
      frame_q.push_back(count);
      sum = cmd + count;
      for (int i = 0; i < n_params; i++) begin
         p = (i < 4) ? prm[8*i +: 8] : 8'($urandom);
         frame_q.push_back(p);
         sum = sum + p;
      end
      frame_q.push_back(sum ^ csum_flip);
      frame_q.push_back(end_byte);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_source_ids(input logic [7:0] h_id, input logic [7:0] c_id);
      csr_write(REG_HANDSET_ID, h_id);
      csr_write(REG_CONTROLLER_ID, c_id);
      csr_valid <= 1'b0;
      handset_id    = h_id;
      controller_id = c_id;
   endtask

   task automatic send_random_buffer();
      logic [7:0] src;
      logic [7:0] src_b;
      logic [7:0] count;
      logic [7:0] flip;
      logic [7:0] end_byte;
      int         n_params;
      int         len;
      src      = $urandom_range(1) ? handset_id : controller_id;
      src_b    = src;
      count    = 8'($urandom_range(MAX_PARAMS));
      n_params = count;
      flip     = '0;
      end_byte = END_MARKER;
      if ($urandom_range(99) < 55) begin
         make_frame(src, src, 8'($urandom), count, n_params, $urandom, flip, end_byte);
      end else begin
         case ($urandom_range(7))
            0: src_b = src ^ 8'($urandom_range(1, 255));
            1: begin
               src   = 8'($urandom);
               src_b = src;
            end
            2: flip = 8'($urandom_range(1, 255));
            3: end_byte = END_MARKER ^ 8'($urandom_range(1, 255));
            4: begin
               count    = 8'($urandom_range(MAX_PARAMS + 1, 255));
               n_params = $urandom_range(0, 6);
            end
            5: n_params = $urandom_range(1) ? count + $urandom_range(1, 3)
                                            : (count > 0 ? count - 1 : 0);
            default: ;
         endcase
         make_frame(src, src_b, 8'($urandom), count, n_params, $urandom, flip, end_byte);
         if ($urandom_range(6) == 0) begin
            // truncated buffer
            len = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > len) void'(frame_q.pop_back());
         end else if ($urandom_range(6) == 0) begin
            // line noise; now and then long enough to pin the byte counter
            len = ($urandom_range(7) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 12);
            frame_q.delete();
            repeat (len) frame_q.push_back(8'($urandom));
         end
      end
      send_frame_q();
   endtask

   task automatic run_chunk(input int byte_goal);
      int stop_at;
      stop_at = bytes_sent + byte_goal;
      while (bytes_sent < stop_at) send_random_buffer();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 32;
      recv_idle_pct = 71;

      // good frames: no params, then all four at extreme values
      make_frame(handset_id, handset_id, 8'h00, 8'd0, 0, '0, '0, END_MARKER);
      send_frame_q();
      make_frame(controller_id, controller_id, 8'hFF, 8'd4, 4, 32'h00FF_00FF, '0, END_MARKER);
      send_frame_q();
      // count over the limit
      make_frame(handset_id, handset_id, 8'h12, 8'd5, 5, 32'hA5A5_A5A5, '0, END_MARKER);
      send_frame_q();
      // repeated source differs
      make_frame(handset_id, controller_id, 8'h34, 8'd1, 1, 32'h0000_0080, '0, END_MARKER);
      send_frame_q();
      // source matches neither id
      make_frame(8'h00, 8'h00, 8'h56, 8'd2, 2, 32'h0000_7F01, '0, END_MARKER);
      send_frame_q();
      // short buffer: one byte with the end flag
      push_byte(8'hFF, 1'b1);
      // bad checksum, then bad end marker
      make_frame(controller_id, controller_id, 8'hC3, 8'd3, 3, 32'h00FF_FFFF, 8'h01,
                 END_MARKER);
      send_frame_q();
      make_frame(handset_id, handset_id, 8'h80, 8'd1, 1, 32'h0000_00FE, '0, 8'h7F);
      send_frame_q();

      run_chunk(CHUNK_BYTES);
      drain_results();

      set_source_ids(8'h00, 8'hFF);
      send_idle_pct = 71;
      recv_idle_pct = 32;
      run_chunk(CHUNK_BYTES);
      drain_results();

      csr_write(REG_SPARE, 8'($urandom));
      set_source_ids(8'hFF, 8'h00);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_chunk(CHUNK_BYTES / 2);
      // hold the sender until the block has handed back every verdict
      drain_results();
      run_chunk(CHUNK_BYTES / 2);
      drain_results();

      set_source_ids(8'($urandom), 8'($urandom));
      run_chunk(CHUNK_BYTES);
      drain_results();

      if (fail_count == 0)
         $display("serial_frame_checker_top: match");
      else
         $display("serial_frame_checker_top: mismatch");
      $finish;
   end

endmodule
